@@ hdl/pdvb_pkg.sv @@
// Shared constants for the posting delta variable-byte encoder.
// No dependencies; used by pdvb_emit and posting_delta_varbyte_encoder_top.
package pdvb_pkg;

    localparam int GROUP_BITS = 7;
    localparam int BYTE_BITS  = 8;

    localparam logic [BYTE_BITS-1:0] STOP_BIT = 8'h80;

endpackage

@@ hdl/pdvb_emit.sv @@
// Byte emitter: walks the 7-bit groups of two values, one byte per beat.
// Depends on pdvb_pkg for group width and stop-bit constants.
module pdvb_emit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load_valid,
    output logic                             o_load_ready,
    input  logic [VALUE_BITS-1:0]            i_val0,
    input  logic [VALUE_BITS-1:0]            i_val1,
    input  logic [$clog2((VALUE_BITS + pdvb_pkg::GROUP_BITS - 1)
                         / pdvb_pkg::GROUP_BITS)-1:0] i_top0,
    input  logic [$clog2((VALUE_BITS + pdvb_pkg::GROUP_BITS - 1)
                         / pdvb_pkg::GROUP_BITS)-1:0] i_top1,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pdvb_pkg::BYTE_BITS-1:0]   o_out_byte,
    output logic                             o_last_byte
);

    localparam int GB = pdvb_pkg::GROUP_BITS;
    localparam int NG = (VALUE_BITS + GB - 1) / GB;
    localparam int PW = NG * GB;
    localparam int GW = $clog2(NG);

    logic                         r_busy;
    logic                         r_sel;
    logic [GW-1:0]                r_grp;
    logic [GW-1:0]                r_top1;
    logic [VALUE_BITS-1:0]        r_val0;
    logic [VALUE_BITS-1:0]        r_val1;
    logic                         r_ov;
    logic [pdvb_pkg::BYTE_BITS-1:0] r_byte;
    logic                         r_last;

    logic                         load;
    logic                         out_free;
    logic                         step;
    logic                         stop;
    logic                         final_beat;
    logic [PW-1:0]                pad;
    logic [GB-1:0]                grp;
    logic [pdvb_pkg::BYTE_BITS-1:0] n_byte;

    assign out_free     = !r_ov || i_ready;
    assign step         = r_busy && out_free;
    assign stop         = (r_grp == '0);
    assign final_beat   = stop && r_sel;
    assign o_load_ready = !r_busy || (step && final_beat);
    assign load         = i_load_valid && o_load_ready;

    // Select the current group of the value being walked.
    always_comb begin
        pad = PW'(r_sel ? r_val1 : r_val0);
        grp = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_grp == GW'(g)) begin
                grp = pad[g*GB +: GB];
            end
        end
        n_byte = {1'b0, grp};
        if (stop) begin
            n_byte = n_byte | pdvb_pkg::STOP_BIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
            r_grp  <= '0;
            r_top1 <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_sel  <= 1'b0;
            r_grp  <= i_top0;
            r_top1 <= i_top1;
        end else if (step) begin
            if (final_beat) begin
                r_busy <= 1'b0;
            end else if (stop) begin
                r_sel <= 1'b1;
                r_grp <= r_top1;
            end else begin
                r_grp <= r_grp - GW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val0 <= i_val0;
            r_val1 <= i_val1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= n_byte;
            r_last <= final_beat;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

    a_last_has_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_byte |-> o_out_byte[pdvb_pkg::BYTE_BITS-1])
        else $error("posting end byte lacks stop bit");

    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_grp <= GW'(NG - 1)))
        else $error("group index out of range");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy)
        else $error("emitter idle after load");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !final_beat && !load |=> r_busy)
        else $error("emitter stopped before posting end");

endmodule

@@ hdl/posting_delta_varbyte_encoder_top.sv @@
// A posting waits in the input stage, is loaded into the emitter, and its first byte
// is registered on the output. One output byte per cycle while i_ready is high; a
// posting codes as 2 to 2*ceil(VALUE_BITS/7) bytes (10 at VALUE_BITS = 32).
// The next posting is taken while the current one is still emitting bytes.
// Reset (synchronous, active low) empties both stages and clears the previous
// document id to zero.
module posting_delta_varbyte_encoder_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_doc_id,
    input  logic [31:0]                    i_term_freq,
    input  logic                           i_first_of_list,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [pdvb_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                           o_last_byte
);

    localparam int GB = pdvb_pkg::GROUP_BITS;
    localparam int NG = (VALUE_BITS + GB - 1) / GB;
    localparam int PW = NG * GB;
    localparam int GW = $clog2(NG);

    // Previous document id, kept at full input width.
    logic [31:0]           r_prev;

    // Input stage: the two values to code and the index of their top group.
    logic                  r_a_valid;
    logic [VALUE_BITS-1:0] r_a_val0;
    logic [VALUE_BITS-1:0] r_a_val1;
    logic [GW-1:0]         r_a_top0;
    logic [GW-1:0]         r_a_top1;

    logic                  in_beat;
    logic                  load_ready;
    logic [VALUE_BITS-1:0] n_val0;
    logic [VALUE_BITS-1:0] n_val1;
    logic [GW-1:0]         n_top0;
    logic [GW-1:0]         n_top1;
    logic [PW-1:0]         pad0;
    logic [PW-1:0]         pad1;

    assign o_ready = !r_a_valid || load_ready;
    assign in_beat = i_valid && o_ready;

    // Raw id on the first posting of a list, else the gap modulo 2^VALUE_BITS.
    // Find the highest nonzero 7-bit group; zero still codes as one group.
    always_comb begin
        if (i_first_of_list) begin
            n_val0 = VALUE_BITS'(i_doc_id);
        end else begin
            n_val0 = VALUE_BITS'(i_doc_id) - VALUE_BITS'(r_prev);
        end
        n_val1 = VALUE_BITS'(i_term_freq);
        pad0   = PW'(n_val0);
        pad1   = PW'(n_val1);
        n_top0 = '0;
        n_top1 = '0;
        for (int g = 1; g < NG; g++) begin
            if (pad0[g*GB +: GB] != '0) begin
                n_top0 = GW'(g);
            end
            if (pad1[g*GB +: GB] != '0) begin
                n_top1 = GW'(g);
            end
        end
    end

    // Every posting, flagged or not, becomes the new previous id.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (in_beat) begin
            r_prev <= i_doc_id;
        end
    end

    // Hold the input stage until the emitter takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_beat) begin
            r_a_valid <= 1'b1;
        end else if (load_ready) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_a_val0 <= n_val0;
            r_a_val1 <= n_val1;
            r_a_top0 <= n_top0;
            r_a_top1 <= n_top1;
        end
    end

    pdvb_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_a_valid),
        .o_load_ready (load_ready),
        .i_val0       (r_a_val0),
        .i_val1       (r_a_val1),
        .i_top0       (r_a_top0),
        .i_top1       (r_a_top1),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for posting_delta_varbyte_encoder_top: delta gaps + variable-byte code.
// Needs hdl/pdvb_pkg.sv, hdl/pdvb_emit.sv and hdl/posting_delta_varbyte_encoder_top.sv.
// Postings go in through a clocked driver; code bytes are checked against a local predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS   = 32;
    localparam int MAX_IDLE     = 17;
    localparam int LONG_HOLD    = 400;     // output hold-off used to back the block up
    localparam int DRAIN_CYCLES = 12;      // well past the first-byte latency
    localparam int CYCLE_LIMIT  = 500_000;

    // One posting waiting to be offered, with the idle cycles to spend before it.
    typedef struct {
        logic [31:0] doc_id;
        logic [31:0] term_freq;
        logic        first_of_list;
        int unsigned idle;
    } t_posting;

    // One expected code byte on the output channel.
    typedef struct packed {
        logic [pdvb_pkg::BYTE_BITS-1:0] code;
        logic                           last;
    } t_code_byte;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [31:0]                    i_doc_id = '0;
    logic [31:0]                    i_term_freq = '0;
    logic                           i_first_of_list = 1'b0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [pdvb_pkg::BYTE_BITS-1:0] o_out_byte;
    logic                           o_last_byte;

    t_posting    posting_q[$];       // postings not yet offered to the block
    t_code_byte  code_bytes_q[$];    // predicted bytes not yet seen on the output
    logic [31:0] prev_doc_id = '0;   // predictor copy of the previous document id

    logic        in_beat = 1'b0;     // input beat happened at the last rising edge
    logic        out_beat = 1'b0;    // output beat happened at the last rising edge
    int unsigned tx_idle_cnt = 0;
    int unsigned rx_wait = 0;
    bit          rx_idle_on = 1'b0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;

    int unsigned n_queued = 0;
    int unsigned n_postings = 0;
    int unsigned n_list_heads = 0;
    int unsigned n_bytes = 0;
    int unsigned n_errors = 0;
    int unsigned cycle_cnt = 0;

    posting_delta_varbyte_encoder_top #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_doc_id(i_doc_id),
        .i_term_freq(i_term_freq),
        .i_first_of_list(i_first_of_list),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_out_byte(o_out_byte),
        .o_last_byte(o_last_byte)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Split a value into 7-bit groups, most significant first, and queue one
    // byte per group. The stop bit goes on the lowest group; a zero value
    // still takes one group, so it codes as a lone stop byte.
    function automatic void queue_value_code(logic [31:0] value, logic ends_posting);
        int          groups;
        logic [31:0] rest;
        t_code_byte  cb;
        groups = 1;
        rest = value >> pdvb_pkg::GROUP_BITS;
        while (rest != 0) begin
            groups++;
            rest = rest >> pdvb_pkg::GROUP_BITS;
        end
        for (int g = groups - 1; g >= 0; g--) begin
            rest = (value >> (g * pdvb_pkg::GROUP_BITS)) & 32'h7F;
            cb.code = rest[pdvb_pkg::BYTE_BITS-1:0];
            if (g == 0) begin
                cb.code = cb.code | pdvb_pkg::STOP_BIT;
            end
            cb.last = ends_posting && (g == 0);
            code_bytes_q.push_back(cb);
        end
    endfunction

    // List heads code the id itself; all other postings code the gap from the
    // previous id, which wraps modulo 2^32 on a descending id. Every posting
    // updates the previous id, head or not.
    function automatic void predict_posting_bytes(logic [31:0] doc_id, logic [31:0] term_freq,
                                                  logic first_of_list);
        logic [31:0] id_code;
        id_code = first_of_list ? doc_id : doc_id - prev_doc_id;
        prev_doc_id = doc_id;
        queue_value_code(id_code, 1'b0);
        queue_value_code(term_freq, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_posting(logic [31:0] doc_id, logic [31:0] term_freq,
                                          logic first_of_list, bit idle_on);
        t_posting p;
        p.doc_id = doc_id;
        p.term_freq = term_freq;
        p.first_of_list = first_of_list;
        p.idle = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        posting_q.push_back(p);
        n_queued++;
    endfunction

    // Value of random bit length up to max_bits, so every group count shows up.
    function automatic logic [31:0] span_value(int unsigned max_bits);
        int unsigned nb;
        nb = $urandom_range(0, max_bits);
        if (nb == 0) begin
            return '0;
        end
        return $urandom >> (32 - nb);
    endfunction

    function automatic logic [31:0] rand_freq();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom;
        end
        return span_value(16);
    endfunction

    // Well-formed list: a flagged head, then ids stepped up by mostly small gaps (a gap may be zero or wrap).
    function automatic void queue_list(int unsigned len, bit idle_on);
        logic [31:0] doc;
        doc = ($urandom_range(0, 3) == 0) ? $urandom : span_value(24);
        queue_posting(doc, rand_freq(), 1'b1, idle_on);
        repeat (len) begin
            doc = doc + (($urandom_range(0, 9) == 0) ? span_value(32) : span_value(12));
            queue_posting(doc, rand_freq(), 1'b0, idle_on);
        end
    endfunction

    // Noise: random ids, random flag, so gaps often wrap.
    function automatic void queue_noise(int unsigned count, bit idle_on);
        repeat (count) begin
            queue_posting($urandom, $urandom, 1'($urandom_range(0, 1)), idle_on);
        end
    endfunction

    function automatic void queue_mix(int unsigned count, bit idle_on);
        int unsigned goal;
        goal = n_queued + count;
        while (n_queued < goal) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_noise($urandom_range(1, 3), idle_on);
            end else begin
                queue_list($urandom_range(0, 8), idle_on);
            end
        end
    endfunction

    // Hold the sender until every posting is taken and every byte is back,
    // then let the latency tail pass so a stray byte would still be caught.
    task automatic wait_drained();
        while (posting_q.size() != 0 || i_valid || code_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge only.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic     drive_valid;
        t_posting cur;
        // Drop valid once the beat went through; reload in the same step if
        // the next posting is due, so valid is written only once here.
        drive_valid = i_valid && !in_beat;
        if (i_rst_n && !drive_valid && posting_q.size() != 0) begin
            if (tx_idle_cnt < posting_q[0].idle) begin
                tx_idle_cnt++;
            end else begin
                cur = posting_q.pop_front();
                tx_idle_cnt = 0;
                drive_valid = 1'b1;
                i_doc_id <= cur.doc_id;
                i_term_freq <= cur.term_freq;
                i_first_of_list <= cur.first_of_list;
            end
        end
        i_valid <= drive_valid;
    end

    // ------------------------------------------------------------------
    // Receiver: draw a stall after every byte, honor long hold-off requests.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic take;
        if (out_beat) begin
            rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rx_wait = LONG_HOLD;
        end
        if (rx_wait > 0) begin
            rx_wait--;
            take = 1'b0;
        end else begin
            take = 1'b1;
        end
        i_ready <= take;
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard: sample on the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_code_byte want;
        in_beat <= i_rst_n && i_valid && o_ready;
        out_beat <= i_rst_n && o_valid && i_ready;
        // Check before predicting: a byte can never belong to a posting taken
        // at the same edge, and a stray byte must not match a fresh prediction.
        if (i_rst_n && o_valid && i_ready) begin
            n_bytes++;
            if (code_bytes_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected byte: expected none, actual code=%02h last=%0b",
                         $time, o_out_byte, o_last_byte);
            end else begin
                want = code_bytes_q.pop_front();
                if (o_out_byte !== want.code) begin
                    n_errors++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.code, o_out_byte);
                end
                if (o_last_byte !== want.last) begin
                    n_errors++;
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last_byte);
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            predict_posting_bytes(i_doc_id, i_term_freq, i_first_of_list);
            n_postings++;
            if (i_first_of_list) begin
                n_list_heads++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles, give up well past the slowest correct run.
    // ------------------------------------------------------------------
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles, %0d bytes still expected",
                 $time, cycle_cnt, code_bytes_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no idling on either side.
        rx_idle_on = 1'b0;
        queue_posting(32'd0, 32'd0, 1'b0, 1'b0);                 // gap from reset id, zeros
        queue_posting(32'd127, 32'd1, 1'b1, 1'b0);               // one-group maximum
        queue_posting(32'd128, 32'd128, 1'b0, 1'b0);             // gap of one, two groups
        queue_posting(32'd128, 32'd127, 1'b0, 1'b0);             // repeated id: zero gap
        queue_posting(32'h0000_3FFF, 32'h0000_4000, 1'b1, 1'b0); // two/three group edge
        queue_posting(32'h001F_FFFF, 32'h0020_0000, 1'b1, 1'b0); // three/four group edge
        queue_posting(32'h0FFF_FFFF, 32'h1000_0000, 1'b1, 1'b0); // four/five group edge
        queue_posting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0); // all ones: ten bytes
        queue_posting(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0); // wraps to a gap of one
        queue_posting(32'd5, 32'hAAAA_AAAA, 1'b1, 1'b0);
        queue_posting(32'd3, 32'h5555_5555, 1'b0, 1'b0);         // descending: huge gap
        queue_posting(32'h8000_0000, 32'h0000_0080, 1'b0, 1'b0);
        queue_posting(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0); // flag on repeated id
        queue_posting(32'h0000_0000, 32'd0, 1'b1, 1'b0);         // head with zero id
        queue_posting(32'h0000_0080, 32'h0000_007F, 1'b0, 1'b0);
        queue_posting(32'h0000_4080, 32'h0000_3FFF, 1'b0, 1'b0);
        queue_posting(32'h7FFF_FFFF, 32'h0FFF_FFFF, 1'b0, 1'b0);
        queue_posting(32'hFFFF_FFFF, 32'h001F_FFFF, 1'b0, 1'b0);
        queue_posting(32'hFFFF_FFFE, 32'd1, 1'b0, 1'b0);
        queue_posting(32'h1234_5678, 32'h8765_4321, 1'b1, 1'b0);
        wait_drained();

        // Random lists with idling on both sides.
        rx_idle_on = 1'b1;
        queue_mix(150, 1'b1);
        wait_drained();

        // Back the block up: sender keeps offering while the receiver holds off.
        rx_idle_on = 1'b0;
        queue_mix(40, 1'b0);
        hold_req++;
        wait_drained();

        // Sender idles, receiver always takes.
        queue_mix(110, 1'b1);
        wait_drained();

        // Sender back to back, receiver stalls.
        rx_idle_on = 1'b1;
        queue_mix(100, 1'b0);
        wait_drained();

        $display("Run covered %0d postings (%0d list heads) and %0d code bytes, %0d mismatches.",
                 n_postings, n_list_heads, n_bytes, n_errors);
        $display("Included group-count edges, zero values, wrapped gaps and a %0d-cycle hold-off.",
                 LONG_HOLD);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pdvb_pkg.sv
hdl/pdvb_emit.sv
hdl/posting_delta_varbyte_encoder_top.sv
tb/tb_top.sv
